[hw/rtl/mexp_pkg.sv]
// Shared types and constants of the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

	// width of every input and result field
	localparam int FIELD_W = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REDUCE,
		ST_STEP,
		ST_SQUARE,
		ST_MULT,
		ST_ADVANCE,
		ST_HOLD
	} mexp_state_t;

endpackage

[hw/rtl/modular_exponentiation.sv]
// Top level of the modular exponentiation block (square-and-multiply).
`timescale 1ns / 1ps

// Computes base_value ** exponent_value mod modulus_value, one transaction in
// and one transaction out. Operands are taken in their low WIDTH bits (all 32
// when WIDTH >= 32). The exponent is scanned from its top bit down: each bit
// costs one modular square and, for a one bit, one modular multiply, both done
// by a single shared shift-and-add multiplier that retires one multiplier bit
// per cycle. A zero exponent, a zero modulus and a modulus of one skip the
// multiplier and finish straight from the check. Zero exponent gives 1 (even
// for modulus 0 or 1); zero modulus with a nonzero exponent gives 0 with
// modulus_error set. in_ready is high only between transactions; a finished
// result sits in an output register, so the next transaction can start while
// the previous result waits.

module modular_exponentiation #(
	parameter int WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mexp_pkg::FIELD_W-1:0]  base_value,
	input  logic [mexp_pkg::FIELD_W-1:0]  exponent_value,
	input  logic [mexp_pkg::FIELD_W-1:0]  modulus_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mexp_pkg::FIELD_W-1:0]  power_result,
	output logic                          modulus_error
);

	import mexp_pkg::*;

	// operand bits actually used from each field
	localparam int OW    = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
	localparam int EXP_W = $clog2(OW);

	mexp_state_t      state_q, state_d;

	logic [WIDTH-1:0] base_q;     // raw base, then base mod m
	logic [OW-1:0]    expo_q;     // exponent, shifted left per bit
	logic [EXP_W-1:0] bit_q;      // exponent bits still to go, minus one
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] acc_q;      // running power, kept below m during the scan
	logic [WIDTH-1:0] res_q;
	logic             err_q;

	logic             out_valid_q;
	logic [FIELD_W-1:0] power_q;
	logic             error_q;

	logic             in_xact;
	logic             ld_out;
	logic             mul_start;
	logic [WIDTH-1:0] mul_a;
	logic [WIDTH-1:0] mul_b;
	logic             mul_done;
	logic [WIDTH-1:0] mul_prod;

	assign in_xact = in_valid && in_ready;

	// shared modular multiplier
	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (m_q),
		.done   (mul_done),
		.product(mul_prod)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ld_out    = 1'b0;
		mul_start = 1'b0;
		mul_a     = acc_q;
		mul_b     = acc_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// special cases finish here; otherwise reduce the base
				if (expo_q == '0 || m_q <= WIDTH'(1)) begin
					state_d = ST_HOLD;
				end else begin
					mul_start = 1'b1;
					mul_a     = WIDTH'(1);
					mul_b     = base_q;
					state_d   = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mul_done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				mul_start = 1'b1;
				state_d   = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (mul_done) begin
					if (expo_q[OW-1]) begin
						mul_start = 1'b1;
						mul_a     = base_q;
						mul_b     = mul_prod;
						state_d   = ST_MULT;
					end else begin
						state_d = ST_ADVANCE;
					end
				end
			end
			ST_MULT: begin
				if (mul_done) begin
					state_d = ST_ADVANCE;
				end
			end
			ST_ADVANCE: begin
				state_d = (bit_q == '0) ? ST_HOLD : ST_STEP;
			end
			ST_HOLD: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					base_q <= WIDTH'(base_value[OW-1:0]);
					expo_q <= exponent_value[OW-1:0];
					m_q    <= WIDTH'(modulus_value[OW-1:0]);
					bit_q  <= EXP_W'(OW - 1);
				end
			end
			ST_CHECK: begin
				if (expo_q == '0) begin
					res_q <= WIDTH'(1);
					err_q <= 1'b0;
				end else begin
					// modulus one gives zero; modulus zero is an error
					res_q <= '0;
					err_q <= (m_q == '0);
				end
			end
			ST_REDUCE: begin
				if (mul_done) begin
					base_q <= mul_prod;
					acc_q  <= WIDTH'(1);
				end
			end
			ST_SQUARE, ST_MULT: begin
				if (mul_done) begin
					acc_q <= mul_prod;
				end
			end
			ST_ADVANCE: begin
				if (bit_q == '0) begin
					res_q <= acc_q;
					err_q <= 1'b0;
				end else begin
					bit_q  <= bit_q - 1'b1;
					expo_q <= {expo_q[OW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			power_q <= FIELD_W'(res_q);
			error_q <= err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign power_result  = power_q;
	assign modulus_error = error_q;

	// an error result always carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && modulus_error |-> power_result == '0)
		else $error("modulus error with nonzero result");

	// the multiplier only reports while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_REDUCE || state_q == ST_SQUARE ||
			state_q == ST_MULT))
		else $error("multiplier done outside a multiply state");

	// the running power stays reduced throughout the exponent scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_SQUARE || state_q == ST_MULT ||
			state_q == ST_ADVANCE) |-> acc_q < m_q)
		else $error("running power not reduced");

	// a loaded result is never dropped before it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

endmodule

[hw/rtl/mexp_mulmod.sv]
// Iterative bit-serial modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module mexp_mulmod #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,       // addend, must be below m
	input  logic [WIDTH-1:0] b,       // multiplier, any value
	input  logic [WIDTH-1:0] m,       // held stable while busy, at least 2
	output logic             done,
	output logic [WIDTH-1:0] product
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] dbl;
	logic [WIDTH-1:0] acc_d;

	// (x + y) mod md for x, y below md, without a carry out
	function automatic logic [WIDTH-1:0] add_mod(
		input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y,
		input logic [WIDTH-1:0] md
	);
		logic [WIDTH-1:0] gap;
		gap = md - y;
		if (x >= gap) begin
			return x - gap;
		end
		return x + y;
	endfunction

	always_comb begin
		dbl   = add_mod(acc_q, acc_q, m);
		acc_d = b_q[WIDTH-1] ? add_mod(dbl, a_q, m) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= acc_d;
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[tb/tb_modular_exponentiation.sv]
// Self-checking testbench of the modular exponentiation block.
`timescale 1ns / 1ps

module tb_modular_exponentiation;

	import mexp_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RAND_ITEMS  = 290;
	localparam int IDLE_PCT    = 12;
	// length of the receiver hold-off
	localparam int HOLD_CYCLES = 3000;
	localparam int WATCHDOG    = 20000;
	localparam int TAIL_CYCLES = 2500;

	typedef struct packed {
		logic [FIELD_W-1:0] power;
		logic               mod_err;
	} power_item_t;

	// Scoreboard: predicts base ** exponent mod modulus and holds the
	// results still owed by the block, oldest first.
	class power_scoreboard;
		power_item_t pending_powers[$];
		int          failures;

		function new();
			failures = 0;
		endfunction

		function power_item_t expected_power(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
				logic [FIELD_W-1:0] m);
			power_item_t      item;
			longint unsigned  acc;
			longint unsigned  bm;
			longint unsigned  mm;
			item.mod_err = 1'b0;
			if (e == '0) begin
				// zero exponent: 1, no reduction, any modulus
				item.power = FIELD_W'(1);
			end else if (m == '0) begin
				item.power   = '0;
				item.mod_err = 1'b1;
			end else begin
				mm  = longint'(m);
				bm  = longint'(b) % mm;
				acc = 1 % mm;
				// operands stay below 2**32, so each product fits 64 bits
				for (int i = FIELD_W - 1; i >= 0; i--) begin
					acc = (acc * acc) % mm;
					if (e[i])
						acc = (acc * bm) % mm;
				end
				item.power = acc[FIELD_W-1:0];
			end
			return item;
		endfunction

		function void note_operands(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
				logic [FIELD_W-1:0] m);
			pending_powers = {pending_powers, expected_power(b, e, m)};
		endfunction

		function void check_power(logic [FIELD_W-1:0] r, logic err);
			power_item_t want;
			if (pending_powers.size() == 0) begin
				$error("unexpected result: power_result=%0h modulus_error=%0b", r, err);
				failures++;
				return;
			end
			want = pending_powers.pop_front();
			if (r !== want.power) begin
				$error("power_result: expected %0h, actual %0h", want.power, r);
				failures++;
			end
			if (err !== want.mod_err) begin
				$error("modulus_error: expected %0b, actual %0b", want.mod_err, err);
				failures++;
			end
		endfunction

		function int owed();
			return pending_powers.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [FIELD_W-1:0] base_value;
	logic [FIELD_W-1:0] exponent_value;
	logic [FIELD_W-1:0] modulus_value;
	logic               out_valid;
	logic               out_ready;
	logic [FIELD_W-1:0] power_result;
	logic               modulus_error;

	power_scoreboard sb = new();
	bit              idle_on;
	bit              hold_req;

	modular_exponentiation u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.modulus_value  (modulus_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.power_result   (power_result),
		.modulus_error  (modulus_error)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Offers one transaction, with optional idle cycles ahead of it, and
	// returns at the edge that accepts it.
	task automatic send_operands(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
			logic [FIELD_W-1:0] m);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		base_value     <= b;
		exponent_value <= e;
		modulus_value  <= m;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_operands(b, e, m);
	endtask

	// called at an accepting edge: drops valid and waits for every result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.owed() > 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] e;
		logic [FIELD_W-1:0] m;
		int                 pick;
		pick = $urandom_range(0, 99);
		b    = $urandom();
		e    = $urandom();
		m    = $urandom();
		if (pick < 20)
			m = $urandom_range(1, 255);
		else if (pick < 30)
			e = (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1)) | $urandom_range(0, 3);
		else if (pick < 36)
			m = '1 - $urandom_range(0, 15);
		else if (pick < 40)
			m = $urandom_range(0, 1);
		else if (pick < 44)
			e = '0;
		else if (pick < 48)
			b = $urandom_range(0, 1) ? '0 : '1;
		send_operands(b, e, m);
	endtask

	// result side: checks each accepted transaction, stalls at random or
	// for a long hold-off when asked
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_power(power_result, modulus_error);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		base_value     <= '0;
		exponent_value <= '0;
		modulus_value  <= '0;
		idle_on  = 1'b1;
		hold_req = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero exponent, with modulus 0, 1 and others
		send_operands(32'd0, 32'd0, 32'd0);
		send_operands(32'd7, 32'd0, 32'd1);
		send_operands(32'hFFFF_FFFF, 32'd0, 32'd13);
		// zero modulus with nonzero exponent flags the error
		send_operands(32'd5, 32'd3, 32'd0);
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		// modulus one
		send_operands(32'd9, 32'd4, 32'd1);
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		// exponent one gives base mod modulus
		send_operands(32'd1000, 32'd1, 32'd7);
		send_operands(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFB);
		// base zero and base equal to the modulus
		send_operands(32'd0, 32'd5, 32'd11);
		send_operands(32'd11, 32'd5, 32'd11);
		// textbook case and small moduli
		send_operands(32'd4, 32'd13, 32'd497);
		send_operands(32'd3, 32'd200, 32'd2);
		send_operands(32'd2, 32'd31, 32'd3);
		// all fields at their maximum, then other large operands
		send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
		send_operands(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
		send_operands(32'h1234_5678, 32'h9ABC_DEF0, 32'h7FFF_FFFF);
		send_operands(32'd2, 32'd32, 32'hFFFF_FFFF);
		send_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
		wait_drained();

		// random part: a stretch without idling first
		idle_on = 1'b0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 60)
				idle_on = 1'b1;
			if (i == 120)
				hold_req = 1'b1;  // receiver stalls, block fills, input backs up
			if (i == 200)
				wait_drained();
			send_random();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.owed() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
